[sv/mhpq_pkg.sv]
// Shared types and codes for the max-heap priority queue.
package mhpq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    // What a cell shows its neighbors: its entry and whether a new value
    // goes ahead of that entry.
    typedef struct packed {
        logic                       vld;
        logic signed [VALUE_W-1:0]  val;
        logic                       ahead;
    } link_t;

endpackage

[sv/mhpq_cell.sv]
// One cell of the sorted row: holds one entry, shifts right on insert, left on remove.
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cmd_t  cmd,
    input  link_t left,
    input  link_t right,
    output link_t link
);

    logic                      vld_reg, vld_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      ahead;

    // The row stays sorted largest first; a new word lands before the first
    // entry it beats, and equal entries keep their place ahead of it.
    assign ahead = !vld_reg || (cmd.value > val_reg);

    always_comb begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (cmd.ins && ahead) begin
            if (left.ahead) begin
                vld_next = left.vld;
                val_next = left.val;
            end else begin
                vld_next = 1'b1;
                val_next = cmd.value;
            end
        end else if (cmd.rem) begin
            vld_next = right.vld;
            val_next = right.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign link.vld   = vld_reg;
    assign link.val   = val_reg;
    assign link.ahead = ahead;

endmodule

[sv/max_heap_priority_queue.sv]
// On accept the row of cells updates and the removed word and status are captured;
// the result register then takes them, with the top and count of the settled row.
// s_ready is low until the result is registered and while it waits on m_ready.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result
// and holds s_ready low.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic signed [VALUE_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VALUE_W-1:0]  m_removed_value,
    output logic [1:0]                 m_status,
    output logic signed [VALUE_W-1:0]  m_top_value,
    output logic [COUNT_W-1:0]         m_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    link_t fwd [DEPTH];
    cmd_t  cmd;

    logic                      accept;
    logic                      full, empty;
    logic [CW-1:0]             count_reg, count_next;
    logic                      busy_reg;
    logic signed [VALUE_W-1:0] removed_reg;
    logic [1:0]                status_reg;
    logic                      m_valid_reg;
    logic signed [VALUE_W-1:0] m_removed_reg, m_top_reg;
    logic [1:0]                m_status_reg;
    logic [COUNT_W-1:0]        m_count_reg;
    logic [CW+COUNT_W-1:0]     count_ext;

    assign s_ready = aresetn && !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);

    assign cmd.ins   = accept && (s_action == ACT_INSERT) && !full;
    assign cmd.rem   = accept && (s_action == ACT_REMOVE) && !empty;
    assign cmd.value = s_value;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            link_t left_in, right_in;
            if (i == 0) begin : g_head
                assign left_in = '{vld: 1'b0, val: '0, ahead: 1'b0};
            end else begin : g_mid_l
                assign left_in = fwd[i-1];
            end
            if (i == DEPTH - 1) begin : g_tail
                assign right_in = '{vld: 1'b0, val: '0, ahead: 1'b0};
            end else begin : g_mid_r
                assign right_in = fwd[i+1];
            end
            mhpq_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .left    (left_in),
                .right   (right_in),
                .link    (fwd[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Report the count modulo the field width.
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            busy_reg  <= accept;
            if (busy_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the removed word and status at accept; the row updates at the same edge.
    always_ff @(posedge aclk) begin
        if (accept) begin
            removed_reg <= cmd.rem ? fwd[0].val : '0;
            priority if (s_action == ACT_INSERT && full) begin
                status_reg <= ST_FULL;
            end else if (s_action == ACT_REMOVE && empty) begin
                status_reg <= ST_EMPTY;
            end else begin
                status_reg <= ST_OK;
            end
        end
        if (busy_reg) begin
            m_removed_reg <= removed_reg;
            m_status_reg  <= status_reg;
            m_top_reg     <= fwd[0].vld ? fwd[0].val : '0;
            m_count_reg   <= count_ext[COUNT_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_removed_reg;
    assign m_status        = m_status_reg;
    assign m_top_value     = m_top_reg;
    assign m_entry_count   = m_count_reg;

endmodule

[sv/mhpq_chk.sv]
// Port-level checker for the max-heap priority queue, bound to the top level.
module mhpq_chk
    import mhpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [VALUE_W-1:0]  m_removed_value,
    input logic [1:0]                 m_status,
    input logic signed [VALUE_W-1:0]  m_top_value,
    input logic [COUNT_W-1:0]         m_entry_count
);

    localparam logic SMALL_DEPTH = (DEPTH < 32);

    // Hold the result word while it stalls.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_top_value)
            && $stable(m_status) && $stable(m_entry_count))
        else $error("result word changed while stalled");

    // No new word is taken while a result waits.
    a_no_accept_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");

    // A word accepted shows up as a result once the result register has been loaded.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("result missing after accept");

    // An empty remove takes nothing and leaves the queue empty.
    a_empty_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_removed_value == '0
            && m_entry_count == '0 && m_top_value == '0)
        else $error("bad empty-remove result");

    // An empty queue has no top and does not report full; checked only for DEPTH below 32.
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_entry_count == '0 && SMALL_DEPTH |-> m_top_value == '0
            && m_status != ST_FULL)
        else $error("nonzero top on empty queue");

endmodule

bind max_heap_priority_queue mhpq_chk #(.DEPTH(DEPTH)) u_mhpq_chk (.*);
